[rtl/ddsc_pkg.sv]
// Shared types and constants for the dual DAC setpoint compensator.
// No dependencies; imported by every module of the block.
package ddsc_pkg;

  localparam int SetW  = 16;
  localparam int CompW = 17;
  localparam int CfgW  = 16;
  localparam int IdxW  = 3;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegCompDelay = 3'd0;
  localparam logic [IdxW-1:0] RegVoltThr   = 3'd1;
  localparam logic [IdxW-1:0] RegCurrThr   = 3'd2;
  localparam logic [IdxW-1:0] RegVoltGain  = 3'd3;
  localparam logic [IdxW-1:0] RegCurrGain  = 3'd4;

  // Configuration reset values
  localparam logic [CfgW-1:0] CompDelayRst = 16'd500;
  localparam logic [CfgW-1:0] VoltThrRst   = 16'd10;
  localparam logic [CfgW-1:0] CurrThrRst   = 16'd100;
  localparam logic [CfgW-1:0] VoltGainRst  = 16'd5591;
  localparam logic [CfgW-1:0] CurrGainRst  = 16'd3355;

  localparam logic [SetW-1:0] CountMax = 16'hFFFF;

  // Per-tick update from a channel controller to its DAC scaler
  typedef struct packed {
    logic                    rewrite;
    logic signed [CompW-1:0] comp;
  } chan_upd_t;

endpackage

[rtl/ddsc_chan_ctrl.sv]
// Compensation controller for one channel: pending flag, delay counter, capture.
// Depends on ddsc_pkg.
module ddsc_chan_ctrl
  import ddsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    req,
  input  logic                    enable,
  input  logic [SetW-1:0]         set_val,
  input  logic [SetW-1:0]         act_val,
  input  logic [CfgW-1:0]         delay,
  output chan_upd_t               upd,
  output logic signed [CompW-1:0] comp
);

  logic            pending;
  logic            pending_next;
  logic [SetW-1:0] count;
  logic [SetW-1:0] count_next;
  logic [SetW-1:0] bumped;
  logic            pend_req;

  // Count while pending and enabled; capture set minus actual at expiry
  always_comb begin
    pend_req     = pending | req;
    bumped       = (count == CountMax) ? count : count + 1'b1;
    pending_next = pend_req;
    count_next   = count;
    upd.rewrite  = 1'b0;
    upd.comp     = '0;
    if (pend_req && enable) begin
      if (bumped >= delay) begin
        pending_next = 1'b0;
        count_next   = '0;
        upd.rewrite  = 1'b1;
        upd.comp     = $signed({1'b0, set_val}) - $signed({1'b0, act_val});
      end else begin
        count_next = bumped;
        upd.comp   = comp;
      end
    end
  end

  // Advance channel state once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      count   <= '0;
      comp    <= '0;
    end else if (step) begin
      pending <= pending_next;
      count   <= count_next;
      comp    <= upd.comp;
    end
  end

endmodule

[rtl/ddsc_dac_scale.sv]
// DAC code generator for one channel: rewrite decision, clamp, Q4.12 scale.
// Depends on ddsc_pkg.
module ddsc_dac_scale
  import ddsc_pkg::*;
#(
  parameter int DAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                floor_one,
  input  logic [SetW-1:0]     set_val,
  input  chan_upd_t           upd,
  input  logic [CfgW-1:0]     gain,
  input  logic [CfgW-1:0]     threshold,
  output logic [DAC_BITS-1:0] code,
  output logic                write,
  output logic                buffer_on
);

  localparam int SumW  = CompW + 1;
  localparam int ProdW = CompW + CfgW + 1;
  localparam int QW    = ProdW - 12;
  localparam logic [QW-1:0] MaxCode = QW'((1 << DAC_BITS) - 1);

  logic [SetW-1:0]         prev_set;
  logic                    write_next;
  logic signed [SumW-1:0]  sum;
  logic [CompW-1:0]        sum_clamped;
  logic [ProdW-1:0]        prod;
  logic [QW-1:0]           scaled;
  logic [DAC_BITS-1:0]     code_next;

  // Clamp the compensated setpoint, scale with round-half-up, limit to DAC range
  always_comb begin
    write_next = upd.rewrite || (set_val != prev_set);
    sum        = $signed({2'b00, set_val}) + $signed({upd.comp[CompW-1], upd.comp});
    if (floor_one && (sum < $signed(SumW'(1)))) begin
      sum_clamped = CompW'(1);
    end else if (sum < 0) begin
      sum_clamped = '0;
    end else begin
      sum_clamped = sum[CompW-1:0];
    end
    prod   = ProdW'(sum_clamped) * ProdW'(gain) + ProdW'(2048);
    scaled = prod[ProdW-1:12];
    if (scaled > MaxCode) begin
      code_next = DAC_BITS'(MaxCode);
    end else begin
      code_next = scaled[DAC_BITS-1:0];
    end
    if (floor_one && (code_next == '0)) begin
      code_next = DAC_BITS'(1);
    end
  end

  // Hold code and buffer enable until the next rewrite
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_set  <= '0;
      code      <= DAC_BITS'(floor_one);
      buffer_on <= 1'b0;
      write     <= 1'b0;
    end else if (step) begin
      write <= write_next;
      if (write_next) begin
        prev_set  <= set_val;
        code      <= code_next;
        buffer_on <= (set_val >= threshold);
      end
    end
  end

endmodule

[rtl/dual_dac_setpoint_compensator_core.sv]
// Top level of the dual DAC setpoint compensator: handshakes, config, channels.
// Depends on ddsc_pkg, ddsc_chan_ctrl and ddsc_dac_scale.
//
// Each accepted input item is one control tick and yields exactly one result.
// An item is captured in an input register; when the result register is free or
// drained, the channel logic and the Q4.12 scaling multiply (one 17x16 product
// per channel) update the state and the result register, so a result passes the
// input register and then the result register, and one item is taken every cycle
// while the result side keeps up. Configuration writes are taken in any cycle
// (cfg_ready is always high) and must be issued only while the block is idle.
module dual_dac_setpoint_compensator_core
  import ddsc_pkg::*;
#(
  parameter int DAC_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  // input items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SetW-1:0]         set_voltage,
  input  logic [SetW-1:0]         meas_voltage,
  input  logic [SetW-1:0]         set_current,
  input  logic [SetW-1:0]         meas_current,
  input  logic                    volt_update_req,
  input  logic                    curr_update_req,
  input  logic                    cc_mode,
  // results
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DAC_BITS-1:0]     volt_dac_code,
  output logic                    volt_dac_write,
  output logic                    volt_buffer_on,
  output logic [DAC_BITS-1:0]     curr_dac_code,
  output logic                    curr_dac_write,
  output logic                    curr_buffer_on,
  output logic signed [CompW-1:0] volt_comp_out,
  output logic signed [CompW-1:0] curr_comp_out,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IdxW-1:0]         cfg_index,
  input  logic [CfgW-1:0]         cfg_data
);

  logic            s1_valid;
  logic [SetW-1:0] s1_set_v;
  logic [SetW-1:0] s1_act_v;
  logic [SetW-1:0] s1_set_i;
  logic [SetW-1:0] s1_act_i;
  logic            s1_vreq;
  logic            s1_ireq;
  logic            s1_cc;
  logic            advance;
  logic            step;

  logic [CfgW-1:0] comp_delay;
  logic [CfgW-1:0] volt_thr;
  logic [CfgW-1:0] curr_thr;
  logic [CfgW-1:0] volt_gain;
  logic [CfgW-1:0] curr_gain;

  chan_upd_t volt_upd;
  chan_upd_t curr_upd;

  // Pipeline flow: stage moves when the result register is free or drained
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign step      = s1_valid && advance;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_delay <= CompDelayRst;
      volt_thr   <= VoltThrRst;
      curr_thr   <= CurrThrRst;
      volt_gain  <= VoltGainRst;
      curr_gain  <= CurrGainRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegCompDelay: comp_delay <= cfg_data;
        RegVoltThr:   volt_thr   <= cfg_data;
        RegCurrThr:   curr_thr   <= cfg_data;
        RegVoltGain:  volt_gain  <= cfg_data;
        RegCurrGain:  curr_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: capture an item on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_set_v <= set_voltage;
      s1_act_v <= meas_voltage;
      s1_set_i <= set_current;
      s1_act_i <= meas_current;
      s1_vreq  <= volt_update_req;
      s1_ireq  <= curr_update_req;
      s1_cc    <= cc_mode;
    end
  end

  // Result valid: load on each step, drop after an output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // Channel controllers; the current channel counts only in CC mode
  ddsc_chan_ctrl u_volt_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .req     (s1_vreq),
    .enable  (1'b1),
    .set_val (s1_set_v),
    .act_val (s1_act_v),
    .delay   (comp_delay),
    .upd     (volt_upd),
    .comp    (volt_comp_out)
  );

  ddsc_chan_ctrl u_curr_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .req     (s1_ireq),
    .enable  (s1_cc),
    .set_val (s1_set_i),
    .act_val (s1_act_i),
    .delay   (comp_delay),
    .upd     (curr_upd),
    .comp    (curr_comp_out)
  );

  // DAC scalers; the voltage code never drops below one
  ddsc_dac_scale #(.DAC_BITS(DAC_BITS)) u_volt_dac (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .floor_one (1'b1),
    .set_val   (s1_set_v),
    .upd       (volt_upd),
    .gain      (volt_gain),
    .threshold (volt_thr),
    .code      (volt_dac_code),
    .write     (volt_dac_write),
    .buffer_on (volt_buffer_on)
  );

  ddsc_dac_scale #(.DAC_BITS(DAC_BITS)) u_curr_dac (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .floor_one (1'b0),
    .set_val   (s1_set_i),
    .upd       (curr_upd),
    .gain      (curr_gain),
    .threshold (curr_thr),
    .code      (curr_dac_code),
    .write     (curr_dac_write),
    .buffer_on (curr_buffer_on)
  );

  // Voltage DAC code stays at or above one
  a_volt_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    volt_dac_code != '0)
    else $error("voltage DAC code is zero");

  // An empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with result register empty");

  // A capture forces a voltage rewrite in the same result
  a_volt_force_write: assert property (@(posedge clk) disable iff (rst)
    (step && volt_upd.rewrite) |=> (volt_dac_write && out_valid))
    else $error("voltage capture without DAC rewrite");

  // A capture forces a current rewrite in the same result
  a_curr_force_write: assert property (@(posedge clk) disable iff (rst)
    (step && curr_upd.rewrite) |=> (curr_dac_write && out_valid))
    else $error("current capture without DAC rewrite");

endmodule

[sim/dual_dac_setpoint_compensator_core_test.sv]
// Self-checking testbench for dual_dac_setpoint_compensator_core.
// Depends on ddsc_pkg and the RTL only. It predicts every tick result in the bench and
// checks it against the block under directed and random ticks, idling and stalls.
module dual_dac_setpoint_compensator_core_test;
  import ddsc_pkg::*;

  localparam int DacBits = 12;
  localparam longint CodeMax = (longint'(1) << DacBits) - 1;
  localparam logic [IdxW-1:0] RegUnused = 3'd5;
  localparam logic [CfgW-1:0] GainUnity = 16'd4096;
  localparam int HoldAtTick = 80;
  localparam int HoldCycles = 200;
  localparam int ReportMax = 10;

  typedef struct packed {
    logic [SetW-1:0] set_v;
    logic [SetW-1:0] act_v;
    logic [SetW-1:0] set_i;
    logic [SetW-1:0] act_i;
    logic            v_req;
    logic            i_req;
    logic            cc;
  } tick_t;

  typedef struct packed {
    logic [DacBits-1:0] v_code;
    logic               v_wr;
    logic               v_buf;
    logic [DacBits-1:0] i_code;
    logic               i_wr;
    logic               i_buf;
    logic [CompW-1:0]   v_comp;
    logic [CompW-1:0]   i_comp;
  } dac_result_t;

  logic clk;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SetW-1:0]     set_voltage = '0;
  logic [SetW-1:0]     meas_voltage = '0;
  logic [SetW-1:0]     set_current = '0;
  logic [SetW-1:0]     meas_current = '0;
  logic                volt_update_req = 1'b0;
  logic                curr_update_req = 1'b0;
  logic                cc_mode = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DacBits-1:0]  volt_dac_code;
  logic                volt_dac_write;
  logic                volt_buffer_on;
  logic [DacBits-1:0]  curr_dac_code;
  logic                curr_dac_write;
  logic                curr_buffer_on;
  logic signed [CompW-1:0] volt_comp_out;
  logic signed [CompW-1:0] curr_comp_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IdxW-1:0]     cfg_index = '0;
  logic [CfgW-1:0]     cfg_data = '0;

  dual_dac_setpoint_compensator_core #(
    .DAC_BITS(DacBits)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .set_voltage    (set_voltage),
    .meas_voltage   (meas_voltage),
    .set_current    (set_current),
    .meas_current   (meas_current),
    .volt_update_req(volt_update_req),
    .curr_update_req(curr_update_req),
    .cc_mode        (cc_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .volt_dac_code  (volt_dac_code),
    .volt_dac_write (volt_dac_write),
    .volt_buffer_on (volt_buffer_on),
    .curr_dac_code  (curr_dac_code),
    .curr_dac_write (curr_dac_write),
    .curr_buffer_on (curr_buffer_on),
    .volt_comp_out  (volt_comp_out),
    .curr_comp_out  (curr_comp_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Bench state
  tick_t       queued_ticks[$];
  dac_result_t pending_dac_results[$];
  tick_t       cur_tick;
  int          ticks_sent = 0;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic [SetW-1:0] gen_set_v = '0;
  logic [SetW-1:0] gen_set_i = '0;

  // Predictor copy of configuration and channel state
  logic [CfgW-1:0]    cfg_delay, cfg_volt_thr, cfg_curr_thr, cfg_volt_gain, cfg_curr_gain;
  logic [SetW-1:0]    m_prev_v, m_prev_i, m_volt_count, m_curr_count;
  logic               m_volt_pending, m_curr_pending, m_volt_force, m_curr_force;
  logic               m_volt_buf, m_curr_buf;
  int                 m_volt_comp, m_curr_comp;
  logic [DacBits-1:0] m_volt_code, m_curr_code;

  task automatic reset_predictor();
    cfg_delay = CompDelayRst;
    cfg_volt_thr = VoltThrRst;
    cfg_curr_thr = CurrThrRst;
    cfg_volt_gain = VoltGainRst;
    cfg_curr_gain = CurrGainRst;
    m_prev_v = '0;
    m_prev_i = '0;
    m_volt_count = '0;
    m_curr_count = '0;
    m_volt_pending = 1'b0;
    m_curr_pending = 1'b0;
    m_volt_force = 1'b0;
    m_curr_force = 1'b0;
    m_volt_buf = 1'b0;
    m_curr_buf = 1'b0;
    m_volt_comp = 0;
    m_curr_comp = 0;
    m_volt_code = DacBits'(1);
    m_curr_code = '0;
  endtask

  task automatic apply_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      RegCompDelay: cfg_delay = data;
      RegVoltThr:   cfg_volt_thr = data;
      RegCurrThr:   cfg_curr_thr = data;
      RegVoltGain:  cfg_volt_gain = data;
      RegCurrGain:  cfg_curr_gain = data;
      default: ;
    endcase
  endtask

  // Saturating tick counter
  function automatic logic [SetW-1:0] count_up(logic [SetW-1:0] cnt);
    return (cnt < CountMax) ? cnt + 1'b1 : cnt;
  endfunction

  // Q4.12 scale with round-half-up, clamped to the DAC range
  function automatic logic [DacBits-1:0] dac_scale(int sum, logic [CfgW-1:0] gain);
    longint prod;
    if (sum < 0) sum = 0;
    prod = (longint'(sum) * longint'(gain) + 2048) >>> 12;
    if (prod > CodeMax) prod = CodeMax;
    return prod[DacBits-1:0];
  endfunction

  // Advance the predicted channels by one control tick
  task automatic advance_tick(input tick_t t, output dac_result_t r);
    int sum;
    logic vwr, iwr;
    vwr = 1'b0;
    iwr = 1'b0;
    if (t.v_req) m_volt_pending = 1'b1;
    if (t.i_req) m_curr_pending = 1'b1;

    // voltage channel: count while pending, else clear count and compensation
    if (m_volt_pending) begin
      m_volt_count = count_up(m_volt_count);
      if (m_volt_count >= cfg_delay) begin
        m_volt_pending = 1'b0;
        m_volt_count = '0;
        m_volt_force = 1'b1;
        m_volt_comp = int'(t.set_v) - int'(t.act_v);
      end
    end else begin
      m_volt_count = '0;
      m_volt_comp = 0;
    end

    // current channel: count only in constant-current mode, hold count otherwise
    if (m_curr_pending && t.cc) begin
      m_curr_count = count_up(m_curr_count);
      if (m_curr_count >= cfg_delay) begin
        m_curr_pending = 1'b0;
        m_curr_count = '0;
        m_curr_force = 1'b1;
        m_curr_comp = int'(t.set_i) - int'(t.act_i);
      end
    end else begin
      m_curr_comp = 0;
    end

    if (m_curr_force || t.set_i != m_prev_i) begin
      m_curr_force = 1'b0;
      m_prev_i = t.set_i;
      m_curr_buf = t.set_i >= cfg_curr_thr;
      m_curr_code = dac_scale(int'(t.set_i) + m_curr_comp, cfg_curr_gain);
      iwr = 1'b1;
    end

    if (m_volt_force || t.set_v != m_prev_v) begin
      m_volt_force = 1'b0;
      m_prev_v = t.set_v;
      m_volt_buf = t.set_v >= cfg_volt_thr;
      sum = int'(t.set_v) + m_volt_comp;
      if (sum < 1) sum = 1;
      m_volt_code = dac_scale(sum, cfg_volt_gain);
      if (m_volt_code < 1) m_volt_code = DacBits'(1);
      vwr = 1'b1;
    end

    r.v_code = m_volt_code;
    r.v_wr = vwr;
    r.v_buf = m_volt_buf;
    r.i_code = m_curr_code;
    r.i_wr = iwr;
    r.i_buf = m_curr_buf;
    r.v_comp = m_volt_comp[CompW-1:0];
    r.i_comp = m_curr_comp[CompW-1:0];
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input driver: offer queued ticks, predict each one on transfer
  always @(posedge clk) begin
    dac_result_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_tick(cur_tick, res);
        pending_dac_results.push_back(res);
        ticks_sent <= ticks_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (queued_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_tick = queued_ticks.pop_front();
          set_voltage <= cur_tick.set_v;
          meas_voltage <= cur_tick.act_v;
          set_current <= cur_tick.set_i;
          meas_current <= cur_tick.act_i;
          volt_update_req <= cur_tick.v_req;
          curr_update_req <= cur_tick.i_req;
          cc_mode <= cur_tick.cc;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, to back the block up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && ticks_sent >= HoldAtTick) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // Result side ready with random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    dac_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.v_code = volt_dac_code;
      got.v_wr = volt_dac_write;
      got.v_buf = volt_buffer_on;
      got.i_code = curr_dac_code;
      got.i_wr = curr_dac_write;
      got.i_buf = curr_buffer_on;
      got.v_comp = volt_comp_out;
      got.i_comp = curr_comp_out;
      if (pending_dac_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < ReportMax)
          $display("ERROR: result with no tick outstanding: v_code=%0d i_code=%0d",
                   got.v_code, got.i_code);
      end else begin
        want = pending_dac_results.pop_front();
        if (got.v_code !== want.v_code || got.v_wr !== want.v_wr ||
            got.v_buf !== want.v_buf || got.i_code !== want.i_code ||
            got.i_wr !== want.i_wr || got.i_buf !== want.i_buf ||
            got.v_comp !== want.v_comp || got.i_comp !== want.i_comp) begin
          errors <= errors + 1;
          if (errors < ReportMax) begin
            $display("ERROR: mismatch at %0t", $realtime);
            $display("  expected v_code=%0d v_wr=%0b v_buf=%0b i_code=%0d i_wr=%0b i_buf=%0b",
                     want.v_code, want.v_wr, want.v_buf, want.i_code, want.i_wr,
                     want.i_buf);
            $display("           v_comp=%0d i_comp=%0d",
                     $signed(want.v_comp), $signed(want.i_comp));
            $display("  actual   v_code=%0d v_wr=%0b v_buf=%0b i_code=%0d i_wr=%0b i_buf=%0b",
                     got.v_code, got.v_wr, got.v_buf, got.i_code, got.i_wr,
                     got.i_buf);
            $display("           v_comp=%0d i_comp=%0d",
                     $signed(got.v_comp), $signed(got.i_comp));
          end
        end
      end
    end
  end

  // Register write over the config channel; predictor follows on transfer
  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [CfgW-1:0] delay, logic [CfgW-1:0] vthr,
                           logic [CfgW-1:0] ithr, logic [CfgW-1:0] vgain,
                           logic [CfgW-1:0] igain);
    write_reg(RegCompDelay, delay);
    write_reg(RegVoltThr, vthr);
    write_reg(RegCurrThr, ithr);
    write_reg(RegVoltGain, vgain);
    write_reg(RegCurrGain, igain);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Wait until every tick is sent and answered, then let the pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (queued_ticks.size() != 0 || in_valid || pending_dac_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_tick(int sv, int av, int si, int ai, bit vr, bit ir, bit cc);
    tick_t t;
    t.set_v = sv[SetW-1:0];
    t.act_v = av[SetW-1:0];
    t.set_i = si[SetW-1:0];
    t.act_i = ai[SetW-1:0];
    t.v_req = vr;
    t.i_req = ir;
    t.cc = cc;
    queued_ticks.push_back(t);
  endtask

  function automatic logic [SetW-1:0] pick_level();
    case ($urandom_range(3))
      0: return SetW'($urandom_range(31));
      1: return SetW'($urandom_range(65535));
      2: return SetW'(65535 - $urandom_range(15));
      default: return SetW'($urandom_range(4095));
    endcase
  endfunction

  // Mostly steady setpoints with occasional steps and update requests
  task automatic queue_random_ticks(int n);
    tick_t t;
    logic [95:0] raw;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 10) begin
        raw = {$urandom, $urandom, $urandom};
        t = raw[$bits(tick_t)-1:0];
      end else begin
        if ($urandom_range(99) < 20) gen_set_v = pick_level();
        if ($urandom_range(99) < 20) gen_set_i = pick_level();
        t.set_v = gen_set_v;
        t.set_i = gen_set_i;
        t.act_v = $urandom_range(1) ? SetW'(gen_set_v + $urandom_range(64) - 32)
                                    : SetW'($urandom_range(65535));
        t.act_i = $urandom_range(1) ? SetW'(gen_set_i + $urandom_range(64) - 32)
                                    : SetW'($urandom_range(65535));
        t.v_req = $urandom_range(99) < 8;
        t.i_req = $urandom_range(99) < 8;
        t.cc = $urandom_range(99) < 85;
      end
      queued_ticks.push_back(t);
    end
  endtask

  // Stimulus sequence
  initial begin
    reset_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: code clamps, thresholds, zero setpoint, request without cc
    @(negedge clk);
    add_tick(0, 0, 0, 0, 0, 0, 0);
    add_tick(65535, 0, 65535, 0, 0, 0, 1);
    add_tick(5, 5, 50, 50, 0, 0, 1);
    add_tick(10, 0, 100, 0, 0, 0, 1);
    add_tick(0, 65535, 0, 65535, 1, 1, 0);
    drain();

    // zero delay: capture on the request tick, negative sums, forced rewrites
    write_all(16'd0, 16'd65535, 16'd0, GainUnity, GainUnity);
    @(negedge clk);
    add_tick(100, 150, 200, 300, 0, 0, 1);
    add_tick(100, 100, 200, 200, 0, 0, 1);
    add_tick(10, 65535, 10, 65535, 1, 1, 1);
    add_tick(65535, 0, 65535, 0, 1, 1, 1);
    add_tick(65535, 0, 65535, 0, 0, 1, 0);
    add_tick(65535, 1, 65535, 1, 0, 0, 1);
    add_tick(0, 3, 0, 7, 1, 1, 1);
    add_tick(0, 0, 0, 0, 1, 1, 1);
    add_tick(40000, 20000, 40000, 20000, 1, 0, 1);
    add_tick(1, 0, 1, 0, 0, 0, 1);
    drain();

    // random phases across settings and idling patterns
    write_all(16'd1, VoltThrRst, CurrThrRst, VoltGainRst, CurrGainRst);
    write_reg(RegUnused, CfgW'($urandom));
    set_idling(0, 0);
    @(negedge clk);
    queue_random_ticks(250);
    drain();

    write_all(16'd3, CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
    set_idling(69, 0);
    @(negedge clk);
    queue_random_ticks(200);
    drain();

    write_all(16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535);
    set_idling(0, 69);
    @(negedge clk);
    queue_random_ticks(200);
    drain();

    write_all(16'd7, 16'd65535, 16'd65535, 16'd0, 16'd0);
    set_idling(20, 20);
    @(negedge clk);
    queue_random_ticks(200);
    drain();

    write_all(16'd65535, 16'd1, 16'd1, GainUnity, GainUnity);
    @(negedge clk);
    queue_random_ticks(40);
    drain();

    if (errors == 0 && pending_dac_results.size() == 0) begin
      $display("dual_dac_setpoint_compensator_core_test: clean");
    end else begin
      $display("dual_dac_setpoint_compensator_core_test: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("dual_dac_setpoint_compensator_core_test: errors");
    $finish;
  end

endmodule
